// ----- src/spd_pkg.sv -----
`default_nettype none
package spd_pkg;

    localparam int unsigned MAX_WINDOW_DEF = 32768;
    localparam logic [17:0] RUN_MAX = 18'h3FFFF;

    localparam logic [15:0] LONG_WIN_RST  = 16'd26460;
    localparam logic [14:0] SHORT_WIN_RST = 15'd13230;
    localparam logic [17:0] START_RUN_RST = 18'd8820;
    localparam logic [17:0] STOP_RUN_RST  = 18'd8820;
    localparam logic [17:0] MIN_LEN_RST   = 18'd22050;
    localparam logic [17:0] MAX_LEN_RST   = 18'd176400;
    localparam logic [9:0]  RATIO_RST     = 10'd100;

    localparam logic [2:0] REG_LONG_WIN  = 3'd0;
    localparam logic [2:0] REG_SHORT_WIN = 3'd1;
    localparam logic [2:0] REG_START_RUN = 3'd2;
    localparam logic [2:0] REG_STOP_RUN  = 3'd3;
    localparam logic [2:0] REG_MIN_LEN   = 3'd4;
    localparam logic [2:0] REG_MAX_LEN   = 3'd5;
    localparam logic [2:0] REG_RATIO     = 3'd6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SUMS,
        ST_DIVIDE,
        ST_MUL,
        ST_DECIDE,
        ST_OUT
    } spd_state_t;

    typedef struct packed {
        logic load;
        logic rd_hist;
        logic upd_sums;
        logic div_start;
        logic mul;
        logic decide;
    } spd_cmd_t;

    typedef struct packed {
        logic full;
        logic div_done;
        logic emit;
    } spd_sts_t;

endpackage
`default_nettype wire

// ----- src/spd_divider.sv -----
`default_nettype none
// two signed 33-bit divisions side by side, one quotient bit a cycle, truncating toward zero
module spd_divider (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [32:0] num_a,
    input  wire logic [15:0] den_a,
    input  wire logic [32:0] num_b,
    input  wire logic [15:0] den_b,
    output logic             done,
    output logic [32:0]      quo_a,
    output logic [32:0]      quo_b
);
    import spd_pkg::*;

    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [32:0] qa_reg, qa_next, qb_reg, qb_next;
    logic [16:0] ra_reg, ra_next, rb_reg, rb_next;
    logic [15:0] da_reg, db_reg;
    logic        na_reg, nb_reg;
    logic [16:0] ta, tb;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        qa_next   = qa_reg;
        qb_next   = qb_reg;
        ra_next   = ra_reg;
        rb_next   = rb_reg;
        ta        = '0;
        tb        = '0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 6'd0;
            qa_next   = num_a[32] ? 33'(-num_a) : num_a;
            qb_next   = num_b[32] ? 33'(-num_b) : num_b;
            ra_next   = '0;
            rb_next   = '0;
        end
        else if (busy_reg)
        begin
            ta = {ra_reg[15:0], qa_reg[32]};
            tb = {rb_reg[15:0], qb_reg[32]};
            qa_next = {qa_reg[31:0], 1'b0};
            qb_next = {qb_reg[31:0], 1'b0};
            if (ta >= {1'b0, da_reg})
            begin
                ra_next = ta - {1'b0, da_reg};
                qa_next[0] = 1'b1;
            end
            else
                ra_next = ta;
            if (tb >= {1'b0, db_reg})
            begin
                rb_next = tb - {1'b0, db_reg};
                qb_next[0] = 1'b1;
            end
            else
                rb_next = tb;
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd32)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        qa_reg <= qa_next;
        qb_reg <= qb_next;
        ra_reg <= ra_next;
        rb_reg <= rb_next;
        if (start)
        begin
            da_reg <= den_a;
            db_reg <= den_b;
            na_reg <= num_a[32];
            nb_reg <= num_b[32];
        end
    end

    assign done  = busy_reg && (cnt_reg == 6'd32);
    assign quo_a = na_reg ? 33'(-qa_next) : qa_next;
    assign quo_b = nb_reg ? 33'(-qb_next) : qb_next;

endmodule
`default_nettype wire

// ----- src/spd_datapath.sv -----
`default_nettype none
module spd_datapath #(
    parameter int unsigned MAX_WINDOW = spd_pkg::MAX_WINDOW_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  spd_pkg::spd_cmd_t     cmd,
    output spd_pkg::spd_sts_t     sts,
    input  wire logic signed [15:0] sample,
    input  wire logic [15:0]      long_win,
    input  wire logic [14:0]      short_win,
    input  wire logic [17:0]      start_run,
    input  wire logic [17:0]      stop_run,
    input  wire logic [17:0]      min_len,
    input  wire logic [17:0]      max_len,
    input  wire logic [9:0]       ratio,
    output logic [31:0]           phrase_begin,
    output logic [31:0]           phrase_end
);
    import spd_pkg::*;

    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int LW = $clog2(MAX_WINDOW + 1);
    localparam int FW = $clog2(MAX_WINDOW + 2);
    localparam logic [FW-1:0] FILL_MAX = FW'(MAX_WINDOW + 1);
    localparam logic [LW-1:0] WIN_MAX  = LW'(MAX_WINDOW);

    logic [15:0] mem [MAX_WINDOW];
    logic [15:0] rd_long_reg, rd_short_reg;

    logic [AW-1:0] wp_reg;
    logic [FW-1:0] fill_reg;
    logic [31:0]   long_sum_reg, short_sum_reg, count_reg;
    logic [17:0]   loud_reg, quiet_reg, plen_reg;
    logic          inph_reg;
    logic signed [15:0] samp_reg;
    logic [LW-1:0] le_reg;
    logic [LW-1:0] se_reg;
    logic [9:0]    rat_reg;
    logic          emit_reg;

    // clamped window lengths
    logic [LW-1:0] le_c, se_c, se_w;
    always_comb
    begin
        if ({1'b0, long_win} < 17'd2)
            le_c = LW'(2);
        else if ({1'b0, long_win} > 17'(MAX_WINDOW))
            le_c = WIN_MAX;
        else
            le_c = LW'(long_win);
        se_w = (short_win == 15'd0) ? LW'(1) : LW'(short_win);
        if ({1'b0, short_win} > 17'(le_c - LW'(1)))
            se_c = le_c - LW'(1);
        else
            se_c = se_w;
    end

    // history indices wrap at the memory depth
    logic [AW-1:0] idx_l, idx_s;
    assign idx_l = (32'(wp_reg) >= 32'(le_reg)) ? AW'(32'(wp_reg) - 32'(le_reg))
                 : AW'(32'(wp_reg) + 32'(MAX_WINDOW) - 32'(le_reg));
    assign idx_s = (32'(wp_reg) >= 32'(se_reg)) ? AW'(32'(wp_reg) - 32'(se_reg))
                 : AW'(32'(wp_reg) + 32'(MAX_WINDOW) - 32'(se_reg));

    always_ff @(posedge clk)
    begin
        if (cmd.rd_hist)
        begin
            rd_long_reg  <= mem[idx_l];
            rd_short_reg <= mem[idx_s];
        end
        if (cmd.upd_sums)
            mem[wp_reg] <= samp_reg;
    end

    logic [FW-1:0] fill_inc;
    assign fill_inc = (fill_reg == FILL_MAX) ? fill_reg : fill_reg + FW'(1);

    // divider
    logic [32:0] num_old, num_rec, q_old, q_rec;
    logic        div_done;
    assign num_old = {long_sum_reg[31], long_sum_reg} - {short_sum_reg[31], short_sum_reg};
    assign num_rec = {short_sum_reg[31], short_sum_reg};

    spd_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num_a (num_old),
        .den_a (16'(le_reg - se_reg)),
        .num_b (num_rec),
        .den_b (16'(se_reg)),
        .done  (div_done),
        .quo_a (q_old),
        .quo_b (q_rec)
    );

    logic signed [32:0] older_reg, recent_reg;
    logic signed [44:0] rec_k_reg, old_k_reg;
    logic [10:0] r_eff;
    assign r_eff = inph_reg ? 11'(11'd1000 - {1'b0, rat_reg}) : {1'b0, rat_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            samp_reg <= sample;
            le_reg   <= le_c;
            se_reg   <= se_c;
            rat_reg  <= (ratio > 10'd1000) ? 10'd1000 : ratio;
        end
        if (div_done)
        begin
            older_reg  <= q_old;
            recent_reg <= q_rec;
        end
        if (cmd.mul)
        begin
            rec_k_reg <= 45'(recent_reg * 45'sd1000);
            old_k_reg <= 45'(older_reg * $signed({1'b0, r_eff}));
        end
    end

    logic [17:0] loud_i, quiet_i, plen_i;
    logic        loud_q, quiet_q;
    assign loud_i  = (loud_reg  == RUN_MAX) ? RUN_MAX : loud_reg  + 18'd1;
    assign quiet_i = (quiet_reg == RUN_MAX) ? RUN_MAX : quiet_reg + 18'd1;
    assign plen_i  = (plen_reg  == RUN_MAX) ? RUN_MAX : plen_reg  + 18'd1;
    assign loud_q  = rec_k_reg >= old_k_reg;
    assign quiet_q = rec_k_reg <= old_k_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= '0;
            fill_reg      <= '0;
            long_sum_reg  <= '0;
            short_sum_reg <= '0;
            count_reg     <= '0;
            loud_reg      <= '0;
            quiet_reg     <= '0;
            plen_reg      <= '0;
            inph_reg      <= 1'b0;
            emit_reg      <= 1'b0;
            phrase_begin  <= '0;
            phrase_end    <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                count_reg <= count_reg + 32'd1;
                fill_reg  <= fill_inc;
            end
            if (cmd.upd_sums)
            begin
                long_sum_reg <= long_sum_reg + 32'(samp_reg)
                    - ((fill_reg > FW'(le_reg)) ? 32'($signed(rd_long_reg)) : 32'd0);
                short_sum_reg <= short_sum_reg + 32'(samp_reg)
                    - ((fill_reg > FW'(se_reg)) ? 32'($signed(rd_short_reg)) : 32'd0);
                wp_reg <= (32'(wp_reg) + 32'd1 >= 32'(MAX_WINDOW)) ? '0 : wp_reg + AW'(1);
            end
            emit_reg <= 1'b0;
            if (cmd.decide)
            begin
                if (!inph_reg)
                begin
                    if (loud_q && loud_i > start_run)
                    begin
                        loud_reg <= '0;
                        inph_reg <= 1'b1;
                        plen_reg <= '0;
                    end
                    else
                        loud_reg <= loud_q ? loud_i : 18'd0;
                end
                else
                begin
                    plen_reg <= plen_i;
                    if ((quiet_q && quiet_i > stop_run) || plen_i > max_len)
                    begin
                        quiet_reg <= '0;
                        inph_reg  <= 1'b0;
                        if (plen_i >= min_len && plen_i <= max_len)
                        begin
                            emit_reg     <= 1'b1;
                            phrase_begin <= count_reg - 32'(plen_i);
                            phrase_end   <= count_reg;
                        end
                    end
                    else
                        quiet_reg <= quiet_q ? quiet_i : 18'd0;
                end
            end
        end
    end

    assign sts.full     = fill_reg > FW'(le_reg);
    assign sts.div_done = div_done;
    assign sts.emit     = emit_reg;

endmodule
`default_nettype wire

// ----- src/spd_ctrl.sv -----
`default_nettype none
module spd_ctrl (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  wire logic         out_stall,
    output spd_pkg::spd_cmd_t cmd,
    input  spd_pkg::spd_sts_t sts
);
    import spd_pkg::*;

    spd_state_t state_reg, state_next;
    logic       ov_reg, ov_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        ov_next    = ov_reg && out_stall;
        in_stall   = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                // result register must be free before a new transaction
                in_stall = ov_reg || sts.emit;
                if (in_valid && !ov_reg && !sts.emit)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.rd_hist = 1'b1;
                state_next  = ST_SUMS;
            end
            ST_SUMS:
            begin
                cmd.upd_sums = 1'b1;
                state_next   = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                // full flag now reflects the updated fill count
                if (!sts.full)
                    state_next = ST_IDLE;
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (sts.div_done)
                    state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                cmd.decide = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
        if (sts.emit)
            ov_next = 1'b1;
    end

    assign out_valid = ov_reg;

endmodule
`default_nettype wire

// ----- src/speech_phrase_detector_top.sv -----
`default_nettype none
// speech phrase detector: one signed 16-bit sample per transaction, phrase
// begin/end sample indices out when a phrase of allowed length closes. each
// sample goes through load, history read and sum update steps; once the long
// window is full it then runs two 33-step bit-serial divisions side by side,
// plus a multiply and a decide step. a new sample is taken only once the last
// one is done and any pending result has left. the sample history is a memory of
// MAX_WINDOW entries, read at two addresses in one cycle and written in another.
module speech_phrase_detector_top #(
    parameter int unsigned MAX_WINDOW = spd_pkg::MAX_WINDOW_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic signed [15:0] sample,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [31:0]             phrase_begin,
    output logic [31:0]             phrase_end,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [4:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    import spd_pkg::*;

    logic [15:0] long_win_reg;
    logic [14:0] short_win_reg;
    logic [17:0] start_run_reg, stop_run_reg, min_len_reg, max_len_reg;
    logic [9:0]  ratio_reg;
    logic [2:0]  ridx;

    assign pready = 1'b1;
    assign ridx   = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_win_reg  <= LONG_WIN_RST;
            short_win_reg <= SHORT_WIN_RST;
            start_run_reg <= START_RUN_RST;
            stop_run_reg  <= STOP_RUN_RST;
            min_len_reg   <= MIN_LEN_RST;
            max_len_reg   <= MAX_LEN_RST;
            ratio_reg     <= RATIO_RST;
        end
        else if (psel && penable && pwrite)
        begin
            case (ridx)
                REG_LONG_WIN:  long_win_reg  <= pwdata[15:0];
                REG_SHORT_WIN: short_win_reg <= pwdata[14:0];
                REG_START_RUN: start_run_reg <= pwdata[17:0];
                REG_STOP_RUN:  stop_run_reg  <= pwdata[17:0];
                REG_MIN_LEN:   min_len_reg   <= pwdata[17:0];
                REG_MAX_LEN:   max_len_reg   <= pwdata[17:0];
                REG_RATIO:     ratio_reg     <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (ridx)
            REG_LONG_WIN:  prdata = 32'(long_win_reg);
            REG_SHORT_WIN: prdata = 32'(short_win_reg);
            REG_START_RUN: prdata = 32'(start_run_reg);
            REG_STOP_RUN:  prdata = 32'(stop_run_reg);
            REG_MIN_LEN:   prdata = 32'(min_len_reg);
            REG_MAX_LEN:   prdata = 32'(max_len_reg);
            REG_RATIO:     prdata = 32'(ratio_reg);
            default:       prdata = 32'd0;
        endcase
    end

    spd_cmd_t cmd;
    spd_sts_t sts;

    spd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    spd_datapath #(.MAX_WINDOW(MAX_WINDOW)) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .sample       (sample),
        .long_win     (long_win_reg),
        .short_win    (short_win_reg),
        .start_run    (start_run_reg),
        .stop_run     (stop_run_reg),
        .min_len      (min_len_reg),
        .max_len      (max_len_reg),
        .ratio        (ratio_reg),
        .phrase_begin (phrase_begin),
        .phrase_end   (phrase_end)
    );

endmodule
`default_nettype wire

// ----- test/spd_checker.sv -----
`default_nettype none
module spd_checker (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic               in_stall,
    input  wire logic signed [15:0] sample,
    input  wire logic               out_valid,
    input  wire logic               out_stall,
    input  wire logic [31:0]        phrase_begin,
    input  wire logic [31:0]        phrase_end,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [4:0]         paddr,
    input  wire logic [31:0]        pwdata,
    input  wire logic               pready,
    output int                      err_count,
    output int                      phrases_pending
);
    import spd_pkg::*;

    typedef struct packed {
        logic [31:0] first;
        logic [31:0] last;
    } phrase_t;

    localparam int unsigned HIST = MAX_WINDOW_DEF;

    phrase_t     phrase_q[$];
    logic [15:0] hist_mem [HIST];
    int unsigned wr_ptr;
    int unsigned fill;
    logic [31:0] long_acc, short_acc, count;
    logic [17:0] loud_cnt, quiet_cnt, length;
    logic        active;

    logic [15:0] cfg_long;
    logic [14:0] cfg_short;
    logic [17:0] cfg_start, cfg_stop, cfg_min, cfg_max;
    logic [9:0]  cfg_ratio;

    function automatic logic [31:0] sext(logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [15:0] back(int unsigned k);
        return hist_mem[(wr_ptr + HIST - k) % HIST];
    endfunction

    function automatic logic [17:0] bump(logic [17:0] v);
        return (v == RUN_MAX) ? v : v + 18'd1;
    endfunction

    task automatic predict_sample(logic [15:0] s);
        int unsigned le, se, ratio;
        longint older, recent;
        logic full;
        le = cfg_long;
        se = cfg_short;
        ratio = (cfg_ratio > 10'd1000) ? 1000 : cfg_ratio;
        if (le < 2) le = 2;
        if (le > HIST) le = HIST;
        if (se < 1) se = 1;
        if (se > le - 1) se = le - 1;
        count = count + 32'd1;
        if (fill <= HIST) fill++;
        long_acc = long_acc + sext(s);
        short_acc = short_acc + sext(s);
        if (fill > se) short_acc = short_acc - sext(back(se));
        full = fill > le;
        if (full) long_acc = long_acc - sext(back(le));
        hist_mem[wr_ptr] = s;
        wr_ptr = (wr_ptr + 1) % HIST;
        if (!full) return;
        older = (longint'($signed(long_acc)) - longint'($signed(short_acc))) / longint'(le - se);
        recent = longint'($signed(short_acc)) / longint'(se);
        if (!active) begin
            if (recent * 1000 >= older * longint'(ratio)) loud_cnt = bump(loud_cnt);
            else loud_cnt = '0;
            if (loud_cnt > cfg_start) begin
                loud_cnt = '0;
                active = 1'b1;
                length = '0;
            end
            return;
        end
        if (recent * 1000 <= older * longint'(1000 - ratio)) quiet_cnt = bump(quiet_cnt);
        else quiet_cnt = '0;
        length = bump(length);
        if (quiet_cnt > cfg_stop || length > cfg_max) begin
            quiet_cnt = '0;
            active = 1'b0;
            if (length >= cfg_min && length <= cfg_max)
                phrase_q.push_back('{first: count - 32'(length), last: count});
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        phrase_t exp_p;
        if (!rst_n) begin
            phrase_q.delete();
            wr_ptr = 0; fill = 0;
            long_acc = '0; short_acc = '0; count = '0;
            loud_cnt = '0; quiet_cnt = '0; length = '0; active = 1'b0;
            cfg_long = LONG_WIN_RST; cfg_short = SHORT_WIN_RST;
            cfg_start = START_RUN_RST; cfg_stop = STOP_RUN_RST;
            cfg_min = MIN_LEN_RST; cfg_max = MAX_LEN_RST; cfg_ratio = RATIO_RST;
            err_count = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    REG_LONG_WIN:  cfg_long  = pwdata[15:0];
                    REG_SHORT_WIN: cfg_short = pwdata[14:0];
                    REG_START_RUN: cfg_start = pwdata[17:0];
                    REG_STOP_RUN:  cfg_stop  = pwdata[17:0];
                    REG_MIN_LEN:   cfg_min   = pwdata[17:0];
                    REG_MAX_LEN:   cfg_max   = pwdata[17:0];
                    REG_RATIO:     cfg_ratio = pwdata[9:0];
                    default: ;
                endcase
            end
            if (out_valid && !out_stall) begin
                if (phrase_q.size() == 0) begin
                    $error("unexpected phrase transaction begin=%0d end=%0d",
                           phrase_begin, phrase_end);
                    err_count++;
                end else begin
                    exp_p = phrase_q.pop_front();
                    if (phrase_begin !== exp_p.first) begin
                        $error("phrase_begin: expected %0d, got %0d", exp_p.first, phrase_begin);
                        err_count++;
                    end
                    if (phrase_end !== exp_p.last) begin
                        $error("phrase_end: expected %0d, got %0d", exp_p.last, phrase_end);
                        err_count++;
                    end
                end
            end
            if (in_valid && !in_stall) predict_sample(sample);
        end
        phrases_pending = phrase_q.size();
    end

endmodule
`default_nettype wire

// ----- test/tb.sv -----
`default_nettype none
module tb;
    import spd_pkg::*;

    logic               clk, rst_n;
    logic               in_valid, in_stall, out_valid, out_stall;
    logic signed [15:0] sample;
    logic [31:0]        phrase_begin, phrase_end;
    logic               psel, penable, pwrite, pready;
    logic [4:0]         paddr;
    logic [31:0]        pwdata, prdata;
    int                 err_count, phrases_pending;
    int                 send_idle, recv_idle;
    longint             cycles;

    speech_phrase_detector_top dut (.*);

    spd_checker chk (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 3000000) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < recv_idle);

    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        @(negedge clk);
        psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
        paddr = {idx, 2'b00}; pwdata = val;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    endtask

    task automatic set_all(logic [31:0] lw, sw, st, sp, mn, mx, rt);
        reg_write(REG_LONG_WIN, lw);
        reg_write(REG_SHORT_WIN, sw);
        reg_write(REG_START_RUN, st);
        reg_write(REG_STOP_RUN, sp);
        reg_write(REG_MIN_LEN, mn);
        reg_write(REG_MAX_LEN, mx);
        reg_write(REG_RATIO, rt);
    endtask

    task automatic push_sample(logic signed [15:0] v);
        @(negedge clk);
        while ($urandom_range(99) < send_idle) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        sample = v;
        do @(posedge clk); while (in_stall);
    endtask

    // drain outstanding phrases, then let the block finish its last sample
    task automatic settle();
        @(negedge clk);
        in_valid = 1'b0;
        while (phrases_pending != 0) @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    // quiet stretches and loud bursts, with some wideband noise mixed in
    task automatic speech_stream(int n);
        int sent, qn, ln;
        sent = 0;
        while (sent < n) begin
            if ($urandom_range(99) < 15) begin
                push_sample(16'($urandom));
                sent++;
            end else begin
                qn = $urandom_range(2, 25);
                ln = $urandom_range(2, 30);
                repeat (qn) push_sample($signed(16'($urandom_range(0, 600))) - 16'sd300);
                repeat (ln) push_sample(16'($urandom_range(3000, 32767)));
                sent += qn + ln;
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0; in_valid = 1'b0; sample = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        send_idle = 0; recv_idle = 0; cycles = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: clamped windows, saturated ratio, extreme samples
        set_all(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd262143, 32'd1023);
        push_sample(16'sh7FFF); push_sample(-16'sh8000); push_sample(16'sd0);
        push_sample(16'sd1); push_sample(-16'sd1); push_sample(16'sh5555);
        push_sample(-16'sh5556); push_sample(16'sh7FFF); push_sample(16'sh7FFF);
        push_sample(16'sd0); push_sample(16'sd0); push_sample(-16'sh8000);
        push_sample(-16'sh8000); push_sample(16'sd2); push_sample(16'sd0);
        push_sample(16'sh7FFF); push_sample(16'sd0); push_sample(16'sd0);
        push_sample(16'sd0); push_sample(16'sd0);
        settle();

        // huge windows: never fill here, but exercise the upper long-window clamp
        set_all(32'd65535, 32'd32767, 32'd262143, 32'd0, 32'd262143, 32'd0, 32'd0);
        repeat (8) push_sample(16'($urandom));
        settle();

        send_idle = 10; recv_idle = 71;
        set_all(32'd8, 32'd3, 32'd2, 32'd2, 32'd3, 32'd20, 32'd100);
        speech_stream(560);
        settle();

        send_idle = 71; recv_idle = 10;
        set_all(32'd16, 32'd20, 32'd0, 32'd262143, 32'd0, 32'd30, 32'd300);
        speech_stream(560);
        settle();

        send_idle = 0; recv_idle = 0;
        set_all(32'd12, 32'd5, 32'd1, 32'd1, 32'd4, 32'd262142, 32'd50);
        speech_stream(560);
        settle();

        if (err_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
`default_nettype wire
